// ===== rtl/rhombus_max_path_sum_unit_defines.svh =====
// assertion macros used by the checker file
`ifndef RHOMBUS_MAX_PATH_SUM_UNIT_DEFINES_SVH
`define RHOMBUS_MAX_PATH_SUM_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define RMPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define RMPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rmps_pkg.sv =====
package rmps_pkg;

  localparam int MaxHalf = 64;
  localparam int Depth   = MaxHalf + 1;
  localparam int ColW    = $clog2(Depth);
  localparam int RowW    = ColW + 1;
  localparam int CellW   = 10;
  localparam int SumW    = 18;
  localparam int HalfW   = 7;
  localparam int DataW   = 32;
  localparam int AddrW   = 3;

  // largest sum a full rhombus of maximal cells can reach
  localparam int PathMaxTop = (2 * MaxHalf + 1) * ((1 << CellW) - 1);

  // register index, taken from paddr[2]
  localparam logic [0:0] RegHalfSize = 1'b0;

  typedef struct packed {
    logic            grow;
    logic            top;
    logic            has_left;
    logic            has_right;
    logic            last;
    logic [ColW-1:0] col;
  } cell_pos_t;

  function automatic logic [ColW-1:0] clamp_half(input logic [HalfW-1:0] half);
    if (int'(half) > MaxHalf) begin
      return ColW'(MaxHalf);
    end
    return ColW'(half);
  endfunction

endpackage

// ===== rtl/rmps_cell_if.sv =====
interface rmps_cell_if;
  logic                        valid;
  logic                        ready;
  logic [rmps_pkg::CellW-1:0]  cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink (input valid, input cell_value, output ready);
endinterface

// ===== rtl/rmps_sum_if.sv =====
interface rmps_sum_if;
  logic                       valid;
  logic                       ready;
  logic [rmps_pkg::SumW-1:0]  path_max;

  modport source (output valid, output path_max, input ready);
  modport sink (input valid, input path_max, output ready);
endinterface

// ===== rtl/rmps_ram.sv =====
module rmps_ram #(
  parameter int Width = 18,
  parameter int Depth = 65,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr0_i,
  input  logic [AddrW-1:0] raddr1_i,
  output logic [Width-1:0] rdata0_o,
  output logic [Width-1:0] rdata1_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata0_q;
  logic [Width-1:0] rdata1_q;

  // a read in the cycle of a write to the same entry returns the old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_q <= mem_q[raddr0_i];
      rdata1_q <= mem_q[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

// ===== rtl/rmps_seq.sv =====
module rmps_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      restart_i,
  input  logic                      advance_i,
  input  logic [rmps_pkg::ColW-1:0] half_i,
  output rmps_pkg::cell_pos_t       pos_o,
  output logic [rmps_pkg::ColW-1:0] raddr0_o,
  output logic [rmps_pkg::ColW-1:0] raddr1_o
);

  logic [rmps_pkg::RowW-1:0] row_q, row_d;
  logic [rmps_pkg::ColW-1:0] col_q, col_d;
  logic [rmps_pkg::RowW-1:0] half_ext;
  logic [rmps_pkg::RowW-1:0] row_width;
  logic [rmps_pkg::RowW-1:0] col_next;
  logic                      grow;
  logic                      row_end;
  logic                      rh_end;

  always_comb begin
    half_ext  = rmps_pkg::RowW'(half_i);
    grow      = row_q <= half_ext;
    col_next  = rmps_pkg::RowW'(col_q) + rmps_pkg::RowW'(1);
    // shrinking rows hold 2h+1-r cells
    row_width = grow ? (row_q + rmps_pkg::RowW'(1)) : ({half_i, 1'b1} - row_q);
    row_end   = col_next >= row_width;
    rh_end    = row_end && (row_q >= {half_i, 1'b0});

    pos_o.grow      = grow;
    pos_o.top       = row_q == '0;
    pos_o.has_left  = col_q != '0;
    pos_o.has_right = col_next <= row_q;
    pos_o.last      = rh_end;
    pos_o.col       = col_q;

    raddr0_o = col_q;
    raddr1_o = grow ? col_q : (col_q + rmps_pkg::ColW'(1));

    row_d = row_q;
    col_d = col_q;
    if (restart_i) begin
      row_d = '0;
      col_d = '0;
    end else if (advance_i) begin
      if (row_end) begin
        col_d = '0;
        row_d = rh_end ? '0 : (row_q + rmps_pkg::RowW'(1));
      end else begin
        col_d = col_next[rmps_pkg::ColW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

// ===== rtl/rmps_calc.sv =====
module rmps_calc (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       restart_i,
  input  logic                       in_beat_i,
  output logic                       in_ready_o,
  input  rmps_pkg::cell_pos_t        pos_i,
  input  logic [rmps_pkg::CellW-1:0] value_i,
  input  logic [rmps_pkg::SumW-1:0]  rd0_i,
  input  logic [rmps_pkg::SumW-1:0]  rd1_i,
  output logic                       we_o,
  output logic [rmps_pkg::ColW-1:0]  waddr_o,
  output logic [rmps_pkg::SumW-1:0]  wdata_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [rmps_pkg::SumW-1:0]  path_max_o
);

  logic                       stg_valid_q, stg_valid_d;
  rmps_pkg::cell_pos_t        stg_pos_q;
  logic [rmps_pkg::CellW-1:0] stg_value_q;
  logic [rmps_pkg::SumW-1:0]  held_q, held_d;
  logic                       lw_valid_q, lw_valid_d;
  logic [rmps_pkg::ColW-1:0]  lw_addr_q;
  logic [rmps_pkg::SumW-1:0]  lw_data_q;
  logic                       out_valid_q, out_valid_d;
  logic [rmps_pkg::SumW-1:0]  out_data_q;

  logic                       out_free;
  logic                       stg_fire;
  logic [rmps_pkg::ColW-1:0]  col1;
  logic [rmps_pkg::SumW-1:0]  old_sum;
  logic [rmps_pkg::SumW-1:0]  nxt_sum;
  logic [rmps_pkg::SumW-1:0]  best;
  logic [rmps_pkg::SumW-1:0]  sum;

  assign out_free   = !out_valid_q || out_ready_i;
  assign stg_fire   = stg_valid_q && (!stg_pos_q.last || out_free);
  assign in_ready_o = !stg_valid_q || stg_fire;

  always_comb begin
    col1 = stg_pos_q.col + rmps_pkg::ColW'(1);
    // the read was taken at the edge of the previous write, so forward it
    old_sum = (lw_valid_q && (lw_addr_q == stg_pos_q.col)) ? lw_data_q : rd0_i;
    nxt_sum = (lw_valid_q && (lw_addr_q == col1)) ? lw_data_q : rd1_i;

    if (stg_pos_q.grow) begin
      if (stg_pos_q.top) begin
        best = '0;
      end else if (stg_pos_q.has_left && stg_pos_q.has_right) begin
        best = (held_q < old_sum) ? old_sum : held_q;
      end else if (stg_pos_q.has_left) begin
        best = held_q;
      end else begin
        best = old_sum;
      end
    end else begin
      best = (old_sum < nxt_sum) ? nxt_sum : old_sum;
    end
    sum = best + rmps_pkg::SumW'(stg_value_q);
  end

  always_comb begin
    stg_valid_d = stg_valid_q;
    if (in_beat_i) begin
      stg_valid_d = 1'b1;
    end else if (stg_fire) begin
      stg_valid_d = 1'b0;
    end

    held_d = held_q;
    if (restart_i) begin
      held_d = '0;
    end else if (stg_fire) begin
      if (stg_pos_q.last) begin
        held_d = '0;
      end else if (stg_pos_q.grow && !stg_pos_q.top) begin
        held_d = old_sum;
      end
    end

    lw_valid_d = lw_valid_q || stg_fire;

    out_valid_d = out_valid_q;
    if (stg_fire && stg_pos_q.last) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      held_q      <= '0;
      lw_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
      held_q      <= held_d;
      lw_valid_q  <= lw_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat_i) begin
      stg_pos_q   <= pos_i;
      stg_value_q <= value_i;
    end
    if (stg_fire) begin
      lw_addr_q <= stg_pos_q.col;
      lw_data_q <= sum;
    end
    if (stg_fire && stg_pos_q.last) begin
      out_data_q <= sum;
    end
  end

  assign we_o        = stg_fire;
  assign waddr_o     = stg_pos_q.col;
  assign wdata_o     = sum;
  assign out_valid_o = out_valid_q;
  assign path_max_o  = out_data_q;

endmodule

// ===== rtl/rhombus_max_path_sum_unit.sv =====
// Maximum top-to-bottom path sum through a number rhombus whose cells arrive
// one per beat in row order: rows grow from 1 to half_size+1 cells, then
// shrink back to 1 (half_size above 64 acts as 64, zero gives a one-cell
// rhombus). One cell is taken every clock cycle with no gaps, unless a final
// cell waits on a stalled path_max; a cell waits in the input register while
// its sum is formed, path_max is registered from the final sum, and the next
// rhombus may follow right behind it. The rate is set by the row buffer, a
// 65 x 18 RAM with one write and two registered reads per cycle; the sum of
// the previous cell is forwarded around it. Writing half_size (byte address
// 0) restarts the rhombus; write it only while no cell is in flight.
module rhombus_max_path_sum_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  rmps_cell_if.sink                   cell_i,
  rmps_sum_if.source                  sum_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rmps_pkg::AddrW-1:0]  paddr,
  input  logic [rmps_pkg::DataW-1:0]  pwdata,
  output logic [rmps_pkg::DataW-1:0]  prdata,
  output logic                        pready
);

  logic [rmps_pkg::HalfW-1:0] half_q, half_d;
  logic                       cfg_wr;
  logic                       restart;
  logic                       in_beat;
  logic                       in_ready;
  logic [rmps_pkg::ColW-1:0]  half_clamped;
  rmps_pkg::cell_pos_t        pos;
  logic [rmps_pkg::ColW-1:0]  raddr0;
  logic [rmps_pkg::ColW-1:0]  raddr1;
  logic [rmps_pkg::SumW-1:0]  rd0;
  logic [rmps_pkg::SumW-1:0]  rd1;
  logic                       we;
  logic [rmps_pkg::ColW-1:0]  waddr;
  logic [rmps_pkg::SumW-1:0]  wdata;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign restart = cfg_wr && (paddr[2:2] == rmps_pkg::RegHalfSize);
  assign prdata  = (paddr[2:2] == rmps_pkg::RegHalfSize) ?
                   rmps_pkg::DataW'(half_q) : '0;

  always_comb begin
    half_d = half_q;
    if (restart) begin
      half_d = pwdata[rmps_pkg::HalfW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= rmps_pkg::HalfW'(1);
    end else begin
      half_q <= half_d;
    end
  end

  assign half_clamped = rmps_pkg::clamp_half(half_q);
  assign cell_i.ready = in_ready;
  assign in_beat      = cell_i.valid && in_ready;

  rmps_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart),
    .advance_i (in_beat),
    .half_i    (half_clamped),
    .pos_o     (pos),
    .raddr0_o  (raddr0),
    .raddr1_o  (raddr1)
  );

  rmps_ram #(
    .Width (rmps_pkg::SumW),
    .Depth (rmps_pkg::Depth)
  ) u_row_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .re_i     (in_beat),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .rdata0_o (rd0),
    .rdata1_o (rd1)
  );

  rmps_calc u_calc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (restart),
    .in_beat_i   (in_beat),
    .in_ready_o  (in_ready),
    .pos_i       (pos),
    .value_i     (cell_i.cell_value),
    .rd0_i       (rd0),
    .rd1_i       (rd1),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .out_valid_o (sum_o.valid),
    .out_ready_i (sum_o.ready),
    .path_max_o  (sum_o.path_max)
  );

endmodule

// ===== rtl/rmps_chk.sv =====
`include "rhombus_max_path_sum_unit_defines.svh"

module rmps_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [rmps_pkg::SumW-1:0] path_max_i
);

  logic in_beat;

  assign in_beat = in_valid_i && in_ready_i;

  // a stalled result beat keeps its value
  `RMPS_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(path_max_i), "path_max changed while stalled")

  // no path can exceed the full-size rhombus of maximal cells
  `RMPS_ASSERT_IMP(a_out_bound, out_valid_i, path_max_i <= rmps_pkg::SumW'(rmps_pkg::PathMaxTop), "path_max out of range")

  // a fresh result rises only after a cell beat, via the input register and the result register
  `RMPS_ASSERT_IMP(a_out_latency, $rose(out_valid_i), $past(in_beat, 2), "result without a cell beat two cycles earlier")

endmodule

bind rhombus_max_path_sum_unit rmps_chk u_rmps_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (cell_i.valid),
  .in_ready_i  (cell_i.ready),
  .out_valid_i (sum_o.valid),
  .out_ready_i (sum_o.ready),
  .path_max_i  (sum_o.path_max)
);
